@@ hw/rtl/drtp_pkg.sv @@
// Package: types, constants and character classes of the RGB triplet parser.
package drtp_pkg;

  localparam int unsigned PREFIX_LEN = 2;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;

  localparam logic [9:0] COMP_MAX   = 10'd255;
  localparam logic [1:0] DIGITS_MAX = 2'd3;
  localparam logic [1:0] COMP_LAST  = 2'd2;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_LEAD,
    PH_DIGITS,
    PH_SEP,
    PH_WS_SEEN,
    PH_COMMA,
    PH_TRAIL
  } phase_e;

  localparam phase_e PH_RESET = (PREFIX_LEN == 0) ? PH_LEAD : PH_PREFIX;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] prefix_cnt;
    logic [1:0] digit_cnt;
    logic [9:0] accum;
    logic [1:0] comp_idx;
    logic [7:0] held_red;
    logic [7:0] held_green;
    logic       err;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_RESET,
    prefix_cnt: 2'd0,
    digit_cnt:  2'd0,
    accum:      10'd0,
    comp_idx:   2'd0,
    held_red:   8'd0,
    held_green: 8'd0,
    err:        1'b0
  };

  typedef struct packed {
    logic       status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

@@ hw/rtl/drtp_if.sv @@
// Interfaces: byte input channel and result output channel.
interface drtp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface drtp_result_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output status, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input status, input red, input green, input blue,
                  output ready);
endinterface

@@ hw/rtl/drtp_core.sv @@
// Parser core: per-byte state update and result formation on NUL.
module drtp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       ch_i,
  output logic             fire_o,
  output drtp_pkg::result_t res_o,
  output drtp_pkg::state_t  st_o
);
  import drtp_pkg::*;

  state_t st_q, st_d;

  // Close the current component with the given value.
  function automatic state_t finish(input state_t s, input logic [9:0] acc);
    state_t r;
    r = s;
    r.accum = acc;
    if (acc > COMP_MAX) begin
      r.err = 1'b1;
    end else begin
      if (s.comp_idx == 2'd0) r.held_red = acc[7:0];
      if (s.comp_idx == 2'd1) r.held_green = acc[7:0];
      r.digit_cnt = 2'd0;
      if (s.comp_idx >= COMP_LAST) begin
        r.phase = PH_TRAIL;
      end else begin
        r.comp_idx = s.comp_idx + 2'd1;
        r.accum = 10'd0;
        r.phase = PH_SEP;
      end
    end
    return r;
  endfunction

  function automatic state_t start(input state_t s, input logic [7:0] c);
    state_t r;
    r = s;
    r.phase = PH_DIGITS;
    r.digit_cnt = 2'd1;
    r.accum = {2'b00, c - CH_ZERO};
    return r;
  endfunction

  logic       ok;
  logic [9:0] acc_ext;
  logic [1:0] pfx_inc;
  state_t     fin;

  always_comb begin
    st_d    = st_q;
    ok      = !st_q.err;
    fire_o  = 1'b0;
    res_o   = '0;
    acc_ext = 10'(st_q.accum * 10'd10) + {2'b00, ch_i - CH_ZERO};
    pfx_inc = st_q.prefix_cnt + 2'd1;
    fin     = finish(st_q, st_q.accum);
    if (step_i && ch_i == CH_NUL) begin
      fire_o = 1'b1;
      if (ok) begin
        if (st_q.phase == PH_DIGITS && st_q.digit_cnt != 2'd0) begin
          if (st_q.comp_idx != COMP_LAST || st_q.accum > COMP_MAX) ok = 1'b0;
        end else if (st_q.phase != PH_TRAIL) begin
          ok = 1'b0;
        end
      end
      res_o.status = !ok;
      res_o.red    = ok ? st_q.held_red : 8'd0;
      res_o.green  = ok ? st_q.held_green : 8'd0;
      res_o.blue   = ok ? st_q.accum[7:0] : 8'd0;
      st_d = STATE_RESET;
    end else if (step_i && !st_q.err) begin
      unique case (st_q.phase)
        PH_PREFIX: begin
          st_d.prefix_cnt = pfx_inc;
          if (pfx_inc >= 2'(PREFIX_LEN)) st_d.phase = PH_LEAD;
        end
        PH_LEAD: begin
          if (is_dig(ch_i))      st_d = start(st_q, ch_i);
          else if (!is_ws(ch_i)) st_d.err = 1'b1;
        end
        PH_DIGITS: begin
          if (is_dig(ch_i)) begin
            st_d.accum = acc_ext;
            st_d.digit_cnt = st_q.digit_cnt + 2'd1;
            if (st_d.digit_cnt >= DIGITS_MAX) st_d = finish(st_d, acc_ext);
          end else if (st_q.digit_cnt == 2'd0 || fin.err) begin
            st_d.err = 1'b1;
          end else begin
            st_d = fin;
            if (fin.phase == PH_TRAIL) begin
              if (!is_ws(ch_i)) st_d.err = 1'b1;
            end else if (is_ws(ch_i)) begin
              st_d.phase = PH_WS_SEEN;
            end else if (ch_i == CH_COMMA) begin
              st_d.phase = PH_COMMA;
            end else begin
              st_d.err = 1'b1;
            end
          end
        end
        PH_SEP: begin
          if (is_ws(ch_i))            st_d.phase = PH_WS_SEEN;
          else if (ch_i == CH_COMMA)  st_d.phase = PH_COMMA;
          else if (is_dig(ch_i))      st_d = start(st_q, ch_i);
          else                        st_d.err = 1'b1;
        end
        PH_WS_SEEN: begin
          if (ch_i == CH_COMMA)  st_d.phase = PH_COMMA;
          else if (!is_ws(ch_i)) st_d.err = 1'b1;
        end
        PH_COMMA: begin
          if (is_dig(ch_i))      st_d = start(st_q, ch_i);
          else if (!is_ws(ch_i)) st_d.err = 1'b1;
        end
        PH_TRAIL: begin
          if (!is_ws(ch_i)) st_d.err = 1'b1;
        end
        default: st_d.err = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

@@ hw/rtl/drtp_out_reg.sv @@
// Result register: holds one finished triplet until the sink takes it.
module drtp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  drtp_pkg::result_t res_i,
  input  logic              ready_i,
  output logic              free_o,
  output logic              valid_o,
  output drtp_pkg::result_t res_o
);
  import drtp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ hw/rtl/decimal_rgb_triplet_parser.sv @@
// Top level: decimal RGB triplet parser with input register and result register.
//
//   channel | dir | payload                   | transaction
//   in_i    | in  | ch[7:0]                   | one byte of the line, NUL ends it
//   out_o   | out | status, red, green, blue  | one result per NUL
//
// One byte per cycle is sustained while no NUL is held; the input register feeds the
// parser core, which loads the result register as a NUL leaves the input register. A
// NUL waits in the input register only while the result register is full and not
// taken; other bytes never wait there. Reset clears all control state and the parser
// returns to identifier skip; every NUL also returns it there.
module decimal_rgb_triplet_parser (
  input logic clk_i,
  input logic rst_ni,
  drtp_byte_if.sink     in_i,
  drtp_result_if.source out_o
);
  import drtp_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_ch_q;
  logic       advance;
  logic       in_take;
  logic       out_free;
  logic       fire;
  result_t    res;
  result_t    out_res;
  state_t     st;

  // Advance a held byte unless it is a NUL facing a full result register.
  assign advance    = s1_valid_q && ((s1_ch_q != CH_NUL) || out_free);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;
  assign s1_valid_d = in_take || (s1_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_ch_q <= in_i.ch;
    end
  end

  drtp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .ch_i   (s1_ch_q),
    .fire_o (fire),
    .res_o  (res),
    .st_o   (st)
  );

  drtp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .res_i   (res),
    .ready_i (out_o.ready),
    .free_o  (out_free),
    .valid_o (out_o.valid),
    .res_o   (out_res)
  );

  assign out_o.status = out_res.status;
  assign out_o.red    = out_res.red;
  assign out_o.green  = out_res.green;
  assign out_o.blue   = out_res.blue;

  // Error results carry zeroed components.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status |-> out_o.red == 8'd0 && out_o.green == 8'd0
                                    && out_o.blue == 8'd0)
    else $error("error result with nonzero component");

  // A new result appears only after a NUL left the input register.
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> s1_valid_q && s1_ch_q == CH_NUL && out_free)
    else $error("result produced without NUL or into a full register");

  // A processed NUL returns the parser to its reset state.
  a_nul_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> st == STATE_RESET)
    else $error("parser state not cleared after NUL");

  // A loaded result stays until taken.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_res))
    else $error("result lost while stalled");

endmodule
